/* src/dpb_pkg.sv */
// shared types, constants and widths of the depth pixel back-projection block
package dpb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  localparam int DEPTH_W  = 16;
  localparam int COLOR_W  = 8;
  localparam int INV_W    = 24;
  localparam int GAIN_W   = 24;
  localparam int CENTER_W = 13;
  localparam int SKIP_W   = 3;
  localparam int DIM_W    = 12;
  localparam int Z_W      = 24;
  localparam int COORD_W  = 32;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam int SKIP_MAX = 4;

  localparam logic [Z_W-1:0] Z_MIN_Q = Z_W'(6553);
  localparam logic [Z_W-1:0] Z_ONE_Q = Z_W'(65536);
  localparam logic [Z_W-1:0] Z_SAT   = {Z_W{1'b1}};

  // depth product and its rounding into Q8.16
  localparam int PROD_W    = DEPTH_W + GAIN_W;
  localparam int Z_SHIFT   = 8;
  localparam int ZR_W      = PROD_W + 1 - Z_SHIFT;

  // offset in half pixels, its magnitude and the projection products
  localparam int POS_W = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int OFF_W = ((POS_W + 1 > CENTER_W) ? POS_W + 1 : CENTER_W) + 1;
  localparam int MAG_W = OFF_W - 1;
  localparam int MZ_W  = MAG_W + Z_W;
  localparam int LO_W  = MZ_W / 2;
  localparam int HI_W  = MZ_W - LO_W;
  localparam int P_W   = MZ_W + INV_W;
  localparam int P_SHIFT = 25;
  localparam int R_W   = P_W + 1 - P_SHIFT;

  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_FOCAL_X  = 3'd0,
    REG_INV_FOCAL_Y  = 3'd1,
    REG_CENTER_X     = 3'd2,
    REG_CENTER_Y     = 3'd3,
    REG_DEPTH_GAIN   = 3'd4,
    REG_SKIP_LOG2    = 3'd5,
    REG_IMAGE_WIDTH  = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [INV_W-1:0]    inv_focal_x;
    logic [INV_W-1:0]    inv_focal_y;
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [GAIN_W-1:0]   depth_gain;
    logic [SKIP_W-1:0]   skip_log2;
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]   u;
    logic [ROW_W-1:0]   v;
    logic [DEPTH_W-1:0] depth_raw;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic               frame_last;
  } q_entry_t;

  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

endpackage

/* src/dpb_if.sv */
// handshake channels of the block: pixel input, point output, register writes
interface dpb_pixel_if
  import dpb_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth_raw;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] red;

  modport source (output valid, depth_raw, blue, green, red, input ready);
  modport sink (input valid, depth_raw, blue, green, red, output ready);
endinterface

interface dpb_point_if
  import dpb_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic [Z_W-1:0]            point_z;
  logic                      point_valid;
  logic [COLOR_W-1:0]        out_blue;
  logic [COLOR_W-1:0]        out_green;
  logic [COLOR_W-1:0]        out_red;
  logic                      frame_last;

  modport source (output valid, point_x, point_y, point_z, point_valid, out_blue, out_green,
                  out_red, frame_last, input ready);
  modport sink (input valid, point_x, point_y, point_z, point_valid, out_blue, out_green,
                out_red, frame_last, output ready);
endinterface

interface dpb_cfg_if
  import dpb_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/dpb_front.sv */
// front end: raster counters, grid test and frame end flag
module dpb_front
  import dpb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  dpb_pixel_if.sink    pixel_in,
  input  logic         q_full,
  output q_push_t      q_push
);

  logic [COL_W-1:0] u;
  logic [ROW_W-1:0] v;
  logic [COL_W-1:0] u_next;
  logic [ROW_W-1:0] v_next;

  logic [SKIP_W-1:0] sk;
  logic [COL_W-1:0]  mask_u;
  logic [ROW_W-1:0]  mask_v;
  logic [COL_W:0]    w_eff;
  logic [ROW_W:0]    h_eff;
  logic [COL_W-1:0]  last_u;
  logic [ROW_W-1:0]  last_v;
  logic              on_grid;
  logic              accept;

  assign pixel_in.ready = !q_full;
  assign accept = pixel_in.valid && pixel_in.ready;

  always_comb begin
    sk = (cfg.skip_log2 > SKIP_W'(SKIP_MAX)) ? SKIP_W'(SKIP_MAX) : cfg.skip_log2;
    mask_u = ~({COL_W{1'b1}} << sk);
    mask_v = ~({ROW_W{1'b1}} << sk);

    if (cfg.image_width == '0) begin
      w_eff = (COL_W+1)'(1);
    end else if (32'(cfg.image_width) > MAX_WIDTH) begin
      w_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W+1)'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_eff = (ROW_W+1)'(1);
    end else if (32'(cfg.image_height) > MAX_HEIGHT) begin
      h_eff = (ROW_W+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (ROW_W+1)'(cfg.image_height);
    end

    last_u = COL_W'(w_eff - (COL_W+1)'(1)) & ~mask_u;
    last_v = ROW_W'(h_eff - (ROW_W+1)'(1)) & ~mask_v;
    on_grid = ((u & mask_u) == '0) && ((v & mask_v) == '0);

    u_next = u;
    v_next = v;
    if (({1'b0, u} + (COL_W+1)'(1)) >= w_eff) begin
      u_next = '0;
      v_next = (({1'b0, v} + (ROW_W+1)'(1)) >= h_eff) ? '0 : v + ROW_W'(1);
    end else begin
      u_next = u + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      u <= '0;
      v <= '0;
    end else if (accept) begin
      u <= u_next;
      v <= v_next;
    end
  end

  always_comb begin
    q_push.push             = accept && on_grid;
    q_push.entry.u          = u;
    q_push.entry.v          = v;
    q_push.entry.depth_raw  = pixel_in.depth_raw;
    q_push.entry.blue       = pixel_in.blue;
    q_push.entry.green      = pixel_in.green;
    q_push.entry.red        = pixel_in.red;
    q_push.entry.frame_last = (u == last_u) && (v == last_v);
  end

endmodule

/* src/dpb_queue.sv */
// short word queue between front and back end
module dpb_queue
  import dpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  q_push_t  q_push,
  output logic     full,
  input  logic     pop,
  output logic     empty,
  output q_entry_t head
);

  q_entry_t         entries [QUEUE_DEPTH];
  logic [QA_W-1:0]  wr_ptr;
  logic [QA_W-1:0]  rd_ptr;
  logic [QC_W-1:0]  count;

  assign full  = (count == QC_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      entries[wr_ptr] <= q_push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= (wr_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QA_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QA_W'(1);
      end
      if (q_push.push && !pop) begin
        count <= count + QC_W'(1);
      end else if (pop && !q_push.push) begin
        count <= count - QC_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push.push |-> !full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QUEUE_DEPTH)) else $error("queue count overflow");

endmodule

/* src/dpb_back.sv */
// back end: metric depth and pinhole back-projection sequencer with output register
module dpb_back
  import dpb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_empty,
  input  q_entry_t    head,
  output logic        pop,
  dpb_point_if.source point_out
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ZMUL = 8'b0000_0010,
    S_ZSAT = 8'b0000_0100,
    S_MZ   = 8'b0000_1000,
    S_PLO  = 8'b0001_0000,
    S_PHI  = 8'b0010_0000,
    S_SUM  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t st;
  state_t st_next;
  logic   ovalid;
  logic   ovalid_next;
  logic   out_free;

  q_entry_t               e;
  logic                   negx;
  logic                   negy;
  logic [MAG_W-1:0]       magx;
  logic [MAG_W-1:0]       magy;
  logic [PROD_W-1:0]      prod;
  logic [Z_W-1:0]         z;
  logic                   zvalid;
  logic [Z_W-1:0]         zeff;
  logic [MZ_W-1:0]        mzx;
  logic [MZ_W-1:0]        mzy;
  logic [LO_W+INV_W-1:0]  plx;
  logic [LO_W+INV_W-1:0]  ply;
  logic [HI_W+INV_W-1:0]  phx;
  logic [HI_W+INV_W-1:0]  phy;
  logic [P_W-1:0]         px;
  logic [P_W-1:0]         py;

  logic signed [COORD_W-1:0] ox;
  logic signed [COORD_W-1:0] oy;
  logic [Z_W-1:0]            oz;
  logic                      ozvalid;
  logic [COLOR_W-1:0]        ob;
  logic [COLOR_W-1:0]        og;
  logic [COLOR_W-1:0]        orr;
  logic                      olast;

  logic signed [OFF_W-1:0] dx;
  logic signed [OFF_W-1:0] dy;
  logic [ZR_W-1:0]         zr;
  logic [Z_W-1:0]          zs;

  function automatic logic [COORD_W-1:0] round_sat(input logic [P_W-1:0] p, input logic neg);
    logic [P_W:0]   rs;
    logic [R_W-1:0] r;
    logic [COORD_W-1:0] res;
    rs = {1'b0, p} + ((P_W+1)'(1) << (P_SHIFT - 1));
    r  = rs[P_W:P_SHIFT];
    if (neg) begin
      if (r > R_W'(64'h8000_0000)) begin
        r = R_W'(64'h8000_0000);
      end
      res = COORD_W'(0) - r[COORD_W-1:0];
    end else begin
      if (r > R_W'(64'h7FFF_FFFF)) begin
        r = R_W'(64'h7FFF_FFFF);
      end
      res = r[COORD_W-1:0];
    end
    return res;
  endfunction

  assign out_free = !ovalid || point_out.ready;
  assign pop = (st == S_IDLE) && !q_empty;

  always_comb begin
    dx = OFF_W'({e.u, 1'b0}) - OFF_W'(cfg.center_x);
    dy = OFF_W'({e.v, 1'b0}) - OFF_W'(cfg.center_y);
    zr = ZR_W'(({1'b0, prod} + (PROD_W+1)'(128)) >> Z_SHIFT);
    zs = (zr > ZR_W'(Z_SAT)) ? Z_SAT : zr[Z_W-1:0];
  end

  always_comb begin
    st_next = st;
    case (st)
      S_IDLE:  if (!q_empty) st_next = S_ZMUL;
      S_ZMUL:  st_next = S_ZSAT;
      S_ZSAT:  st_next = S_MZ;
      S_MZ:    st_next = S_PLO;
      S_PLO:   st_next = S_PHI;
      S_PHI:   st_next = S_SUM;
      S_SUM:   st_next = S_OUT;
      S_OUT:   if (out_free) st_next = S_IDLE;
      default: st_next = S_IDLE;
    endcase
    ovalid_next = ovalid;
    if (ovalid && point_out.ready) begin
      ovalid_next = 1'b0;
    end
    if (st == S_OUT && out_free) begin
      ovalid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      st     <= st_next;
      ovalid <= ovalid_next;
    end
  end

  always_ff @(posedge clk) begin
    case (st)
      S_IDLE: begin
        if (pop) begin
          e <= head;
        end
      end
      S_ZMUL: begin
        prod <= PROD_W'(e.depth_raw * cfg.depth_gain);
        negx <= dx[OFF_W-1];
        negy <= dy[OFF_W-1];
        magx <= dx[OFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        magy <= dy[OFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      end
      S_ZSAT: begin
        z      <= zs;
        zvalid <= zs > Z_MIN_Q;
        zeff   <= (zs > Z_MIN_Q) ? zs : Z_ONE_Q;
      end
      S_MZ: begin
        mzx <= MZ_W'(magx * zeff);
        mzy <= MZ_W'(magy * zeff);
      end
      S_PLO: begin
        plx <= (LO_W+INV_W)'(mzx[LO_W-1:0] * cfg.inv_focal_x);
        ply <= (LO_W+INV_W)'(mzy[LO_W-1:0] * cfg.inv_focal_y);
      end
      S_PHI: begin
        phx <= (HI_W+INV_W)'(mzx[MZ_W-1:LO_W] * cfg.inv_focal_x);
        phy <= (HI_W+INV_W)'(mzy[MZ_W-1:LO_W] * cfg.inv_focal_y);
      end
      S_SUM: begin
        px <= {phx, {LO_W{1'b0}}} + P_W'(plx);
        py <= {phy, {LO_W{1'b0}}} + P_W'(ply);
      end
      S_OUT: begin
        if (out_free) begin
          ox      <= round_sat(px, negx);
          oy      <= round_sat(py, negy);
          oz      <= zvalid ? z : '0;
          ozvalid <= zvalid;
          ob      <= e.blue;
          og      <= e.green;
          orr     <= e.red;
          olast   <= e.frame_last;
        end
      end
      default: begin
      end
    endcase
  end

  assign point_out.valid       = ovalid;
  assign point_out.point_x     = ox;
  assign point_out.point_y     = oy;
  assign point_out.point_z     = oz;
  assign point_out.point_valid = ozvalid;
  assign point_out.out_blue    = ob;
  assign point_out.out_green   = og;
  assign point_out.out_red     = orr;
  assign point_out.frame_last  = olast;

  a_valid_depth: assert property (@(posedge clk) disable iff (rst)
    ovalid && ozvalid |-> oz > Z_MIN_Q) else $error("valid point at or below minimum depth");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    ovalid && !ozvalid |-> oz == '0) else $error("invalid point with nonzero depth");
  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(ovalid) |-> $past(st) == S_OUT) else $error("output loaded outside final step");

endmodule

/* src/depth_pixel_backprojection_core.sv */
// top level of the depth pixel back-projection block with its register file
//
// usage:
//   pixel_in  - one rgb-d pixel word per handshake, raster order, row by row
//   point_out - one point word for each pixel on the subsampling grid, with
//               metric x, y, z, a valid flag, the colour bytes and frame_last
//   cfg       - register writes, index per the register list, always ready;
//               write only while no pixel is in flight
// a pixel is taken in the cycle it is offered while the four-word queue has
// room; pixels off the grid are taken under the same condition and produce nothing
// each grid point goes through the projection sequencer step by step (queue pop,
// depth multiply, saturate, offset times depth, two split multiplies, sum, round);
// it pops no new point until the last one is loaded into the output register, and
// an accepted pixel reaches that register through the queue and the sequencer
// a stalled receiver holds the output register; the sequencer waits in its
// last step and the queue then fills, after which pixel_in.ready drops
// reset clears the counters, queue and output, and loads the default registers
module depth_pixel_backprojection_core
  import dpb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  dpb_pixel_if.sink    pixel_in,
  dpb_point_if.source  point_out,
  dpb_cfg_if.sink      cfg
);

  cfg_t     regs;
  q_push_t  q_push;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  q_entry_t q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.inv_focal_x  <= INV_W'(31957);
      regs.inv_focal_y  <= INV_W'(31957);
      regs.center_x     <= CENTER_W'(639);
      regs.center_y     <= CENTER_W'(479);
      regs.depth_gain   <= GAIN_W'(16777);
      regs.skip_log2    <= SKIP_W'(1);
      regs.image_width  <= DIM_W'(640);
      regs.image_height <= DIM_W'(480);
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_INV_FOCAL_X:  regs.inv_focal_x  <= cfg.data[INV_W-1:0];
        REG_INV_FOCAL_Y:  regs.inv_focal_y  <= cfg.data[INV_W-1:0];
        REG_CENTER_X:     regs.center_x     <= cfg.data[CENTER_W-1:0];
        REG_CENTER_Y:     regs.center_y     <= cfg.data[CENTER_W-1:0];
        REG_DEPTH_GAIN:   regs.depth_gain   <= cfg.data[GAIN_W-1:0];
        REG_SKIP_LOG2:    regs.skip_log2    <= cfg.data[SKIP_W-1:0];
        REG_IMAGE_WIDTH:  regs.image_width  <= cfg.data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: regs.image_height <= cfg.data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dpb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (regs),
    .pixel_in (pixel_in),
    .q_full   (q_full),
    .q_push   (q_push)
  );

  dpb_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .head   (q_head)
  );

  dpb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .q_empty   (q_empty),
    .head      (q_head),
    .pop       (q_pop),
    .point_out (point_out)
  );

endmodule

/* bench/depth_pixel_backprojection_core_tb.sv */
// self-checking regression of the depth back-projection core: directed table, a stall run, then random frames
module depth_pixel_backprojection_core_tb
  import dpb_pkg::*;
;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_LEN     = 200;
  localparam int IDLE_PCT     = 38;
  localparam int RANDOM_SETS  = 11;
  localparam int STALL_WORDS  = 300;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth_raw;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [Z_W-1:0]            point_z;
    logic                      point_valid;
    logic [COLOR_W-1:0]        out_blue;
    logic [COLOR_W-1:0]        out_green;
    logic [COLOR_W-1:0]        out_red;
    logic                      frame_last;
  } point_t;

  typedef struct packed {
    logic                  is_write;
    reg_idx_t              idx;
    logic [CFG_DATA_W-1:0] data;
    pixel_t                px;
    logic                  typed;
    point_t                want;
  } stim_row_t;

  logic clk;
  logic rst;

  dpb_pixel_if pix_if ();
  dpb_point_if pt_if ();
  dpb_cfg_if   cfg_if ();

  depth_pixel_backprojection_core uut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pix_if),
    .point_out (pt_if),
    .cfg       (cfg_if)
  );

  cfg_t        cam_regs;
  int unsigned col_pos;
  int unsigned row_pos;
  point_t      pending_points[$];
  stim_row_t   table_rows[$];
  int          pixels_sent;
  int          points_checked;
  int          regs_written;
  int          mismatches;
  bit          no_idle;
  bit          hold_request;
  bit          hold_done;
  int          hold_cycles;
  int          quiet_cycles;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic int unsigned dim_limit(input logic [DIM_W-1:0] d, input int unsigned lim);
    if (d == 0) return 1;
    if (d > lim) return lim;
    return 32'(d);
  endfunction

  function automatic logic signed [COORD_W-1:0] backproject_axis(input int unsigned pos,
      input logic [CENTER_W-1:0] ctr, input logic [Z_W-1:0] zq, input logic [INV_W-1:0] inv);
    longint          off;
    longint unsigned mag;
    longint unsigned prod;
    longint unsigned r;
    off = 2 * longint'(pos) - longint'(ctr);
    mag = (off < 0) ? -off : off;
    prod = mag * zq * inv;
    r = (prod + (64'd1 << 24)) >> 25;
    if (off < 0) begin
      if (r > 64'h8000_0000) r = 64'h8000_0000;
      return -(r[COORD_W-1:0]);
    end
    if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
    return r[COORD_W-1:0];
  endfunction

  // expected point of one pixel at the current raster position; advances the position
  function automatic bit predict_point(input pixel_t px, output point_t pt);
    int unsigned     sk;
    int unsigned     mask;
    int unsigned     w;
    int unsigned     h;
    longint unsigned zr;
    logic [Z_W-1:0]  z;
    logic [Z_W-1:0]  zeff;
    bit              ok;
    bit              hit;
    sk = (32'(cam_regs.skip_log2) > SKIP_MAX) ? SKIP_MAX : 32'(cam_regs.skip_log2);
    mask = (1 << sk) - 1;
    w = dim_limit(cam_regs.image_width, MAX_WIDTH);
    h = dim_limit(cam_regs.image_height, MAX_HEIGHT);
    hit = ((col_pos & mask) == 0) && ((row_pos & mask) == 0);
    pt = '0;
    if (hit) begin
      zr = 64'(px.depth_raw);
      zr = (zr * cam_regs.depth_gain + 128) >> 8;
      z = (zr > Z_SAT) ? Z_SAT : zr[Z_W-1:0];
      ok = z > Z_MIN_Q;
      zeff = ok ? z : Z_ONE_Q;
      pt.point_x = backproject_axis(col_pos, cam_regs.center_x, zeff, cam_regs.inv_focal_x);
      pt.point_y = backproject_axis(row_pos, cam_regs.center_y, zeff, cam_regs.inv_focal_y);
      pt.point_z = ok ? z : '0;
      pt.point_valid = ok;
      pt.out_blue = px.blue;
      pt.out_green = px.green;
      pt.out_red = px.red;
      pt.frame_last = (col_pos == ((w - 1) & ~mask)) && (row_pos == ((h - 1) & ~mask));
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    return hit;
  endfunction

  function automatic void tab_wr(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.idx = idx;
    row.data = val;
    table_rows.insert(table_rows.size(), row);
  endfunction

  function automatic void tab_px(input logic [DEPTH_W-1:0] d, input logic [COLOR_W-1:0] b,
      input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r);
    stim_row_t row;
    row = '0;
    row.px = '{d, b, g, r};
    table_rows.insert(table_rows.size(), row);
  endfunction

  function automatic void tab_pt(input logic [DEPTH_W-1:0] d, input logic [COLOR_W-1:0] b,
      input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r,
      input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
      input logic [Z_W-1:0] z, input logic ok, input logic last);
    stim_row_t row;
    row = '0;
    row.px = '{d, b, g, r};
    row.typed = 1'b1;
    row.want = '{x, y, z, ok, b, g, r, last};
    table_rows.insert(table_rows.size(), row);
  endfunction

  function automatic logic [23:0] rand_scale();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom());
      default: return 24'($urandom_range(1000, 100000));
    endcase
  endfunction

  function automatic logic [CENTER_W-1:0] rand_center();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {CENTER_W{1'b1}};
      2: return CENTER_W'($urandom());
      default: return CENTER_W'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] rand_dim(input int unsigned top);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DIM_W'($urandom_range(MAX_WIDTH + 1, 4095));
      2: return DIM_W'(MAX_WIDTH);
      default: return DIM_W'($urandom_range(1, top));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.blue = COLOR_W'($urandom());
    px.green = COLOR_W'($urandom());
    px.red = COLOR_W'($urandom());
    case ($urandom_range(0, 9))
      0: px.depth_raw = '0;
      1: px.depth_raw = '1;
      2: px.depth_raw = DEPTH_W'($urandom_range(0, 63));
      3: px.depth_raw = DEPTH_W'($urandom_range(6400, 6700));
      default: px.depth_raw = DEPTH_W'($urandom());
    endcase
    return px;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    regs_written++;
    case (idx)
      REG_INV_FOCAL_X:  cam_regs.inv_focal_x  = val[INV_W-1:0];
      REG_INV_FOCAL_Y:  cam_regs.inv_focal_y  = val[INV_W-1:0];
      REG_CENTER_X:     cam_regs.center_x     = val[CENTER_W-1:0];
      REG_CENTER_Y:     cam_regs.center_y     = val[CENTER_W-1:0];
      REG_DEPTH_GAIN:   cam_regs.depth_gain   = val[GAIN_W-1:0];
      REG_SKIP_LOG2:    cam_regs.skip_log2    = val[SKIP_W-1:0];
      REG_IMAGE_WIDTH:  cam_regs.image_width  = val[DIM_W-1:0];
      REG_IMAGE_HEIGHT: cam_regs.image_height = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(input logic [INV_W-1:0] ifx, input logic [INV_W-1:0] ify,
      input logic [CENTER_W-1:0] cx, input logic [CENTER_W-1:0] cy,
      input logic [GAIN_W-1:0] gain, input logic [SKIP_W-1:0] sk,
      input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    write_reg(REG_INV_FOCAL_X, CFG_DATA_W'(ifx));
    write_reg(REG_INV_FOCAL_Y, CFG_DATA_W'(ify));
    write_reg(REG_CENTER_X, CFG_DATA_W'(cx));
    write_reg(REG_CENTER_Y, CFG_DATA_W'(cy));
    write_reg(REG_DEPTH_GAIN, CFG_DATA_W'(gain));
    write_reg(REG_SKIP_LOG2, CFG_DATA_W'(sk));
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_pixel(input pixel_t px, input bit typed, input point_t want);
    point_t guess;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      pix_if.valid <= 1'b0;
      @(posedge clk);
    end
    pix_if.valid     <= 1'b1;
    pix_if.depth_raw <= px.depth_raw;
    pix_if.blue      <= px.blue;
    pix_if.green     <= px.green;
    pix_if.red       <= px.red;
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
    if (predict_point(px, guess)) begin
      pending_points.insert(pending_points.size(), typed ? want : guess);
    end
  endtask

  // let expected point words still in the pipe clear before registers change
  task automatic drain_points();
    pix_if.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_point(input point_t got);
    point_t want;
    bit     bad;
    if (pending_points.size() == 0) begin
      $error("point word with nothing expected: x %0d y %0d z %0d",
             got.point_x, got.point_y, got.point_z);
      mismatches++;
      return;
    end
    want = pending_points.pop_front();
    points_checked++;
    bad = 1'b0;
    if (got.point_x !== want.point_x) begin
      $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
      bad = 1'b1;
    end
    if (got.point_y !== want.point_y) begin
      $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
      bad = 1'b1;
    end
    if (got.point_z !== want.point_z) begin
      $error("point_z: expected %0d, got %0d", want.point_z, got.point_z);
      bad = 1'b1;
    end
    if (got.point_valid !== want.point_valid) begin
      $error("point_valid: expected %0d, got %0d", want.point_valid, got.point_valid);
      bad = 1'b1;
    end
    if (got.out_blue !== want.out_blue) begin
      $error("out_blue: expected %0d, got %0d", want.out_blue, got.out_blue);
      bad = 1'b1;
    end
    if (got.out_green !== want.out_green) begin
      $error("out_green: expected %0d, got %0d", want.out_green, got.out_green);
      bad = 1'b1;
    end
    if (got.out_red !== want.out_red) begin
      $error("out_red: expected %0d, got %0d", want.out_red, got.out_red);
      bad = 1'b1;
    end
    if (got.frame_last !== want.frame_last) begin
      $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
      bad = 1'b1;
    end
    if (bad) mismatches++;
  endtask

  // point receiver with random stalls and one long hold-off
  initial begin
    point_t got;
    pt_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && pt_if.valid && pt_if.ready) begin
        got.point_x     = pt_if.point_x;
        got.point_y     = pt_if.point_y;
        got.point_z     = pt_if.point_z;
        got.point_valid = pt_if.point_valid;
        got.out_blue    = pt_if.out_blue;
        got.out_green   = pt_if.out_green;
        got.out_red     = pt_if.out_red;
        got.frame_last  = pt_if.frame_last;
        check_point(got);
      end
      if (rst) begin
        pt_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        pt_if.ready <= 1'b0;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        hold_cycles = HOLD_LEN;
        pt_if.ready <= 1'b0;
      end else begin
        pt_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any accepted word
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (pix_if.valid && pix_if.ready) || (pt_if.valid && pt_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("depth_pixel_backprojection_core regression: fail");
    $finish;
  end

  initial begin
    rst = 1'b1;
    pix_if.valid = 1'b0;
    pix_if.depth_raw = '0;
    pix_if.blue = '0;
    pix_if.green = '0;
    pix_if.red = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_INV_FOCAL_X;
    cfg_if.data = '0;
    cam_regs.inv_focal_x = INV_W'(31957);
    cam_regs.inv_focal_y = INV_W'(31957);
    cam_regs.center_x = CENTER_W'(639);
    cam_regs.center_y = CENTER_W'(479);
    cam_regs.depth_gain = GAIN_W'(16777);
    cam_regs.skip_log2 = SKIP_W'(1);
    cam_regs.image_width = DIM_W'(640);
    cam_regs.image_height = DIM_W'(480);
    col_pos = 0;
    row_pos = 0;
    pixels_sent = 0;
    points_checked = 0;
    regs_written = 0;
    mismatches = 0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    hold_done = 1'b0;
    hold_cycles = 0;

    // reset defaults: one grid pixel, one off the grid
    tab_px(16'd1000, 8'h12, 8'h34, 8'h56);
    tab_px(16'd0, 8'hFF, 8'hFF, 8'hFF);
    // zero focal reciprocals give x = y = 0, unit gain gives z = depth, 4x2 frame mid-row
    tab_wr(REG_INV_FOCAL_X, 24'd0);
    tab_wr(REG_INV_FOCAL_Y, 24'd0);
    tab_wr(REG_DEPTH_GAIN, 24'd256);
    tab_wr(REG_SKIP_LOG2, 24'd0);
    tab_wr(REG_IMAGE_WIDTH, 24'd4);
    tab_wr(REG_IMAGE_HEIGHT, 24'd2);
    tab_pt(16'd0, 8'h00, 8'h00, 8'h00, 0, 0, 24'd0, 1'b0, 1'b0);
    tab_pt(16'd6553, 8'hFF, 8'h00, 8'hFF, 0, 0, 24'd0, 1'b0, 1'b0);
    tab_pt(16'd6554, 8'h00, 8'hFF, 8'h00, 0, 0, 24'd6554, 1'b1, 1'b0);
    tab_pt(16'd65535, 8'hFF, 8'hFF, 8'hFF, 0, 0, 24'd65535, 1'b1, 1'b0);
    tab_pt(16'd1, 8'h01, 8'h80, 8'h7F, 0, 0, 24'd0, 1'b0, 1'b0);
    tab_pt(16'd40000, 8'hA5, 8'h5A, 8'h3C, 0, 0, 24'd40000, 1'b1, 1'b1);
    tab_pt(16'd7000, 8'h10, 8'h20, 8'h30, 0, 0, 24'd7000, 1'b1, 1'b0);
    tab_pt(16'd100, 8'hC3, 8'h3C, 8'h96, 0, 0, 24'd0, 1'b0, 1'b0);
    // full-scale gain saturates z
    tab_wr(REG_DEPTH_GAIN, 24'hFFFFFF);
    tab_pt(16'd65535, 8'h55, 8'hAA, 8'h0F, 0, 0, 24'hFFFFFF, 1'b1, 1'b0);
    tab_pt(16'd0, 8'hF0, 8'h0F, 8'hAA, 0, 0, 24'd0, 1'b0, 1'b0);
    // zero dimensions act as one, oversized skip acts as 16, row past the height wraps
    tab_wr(REG_IMAGE_WIDTH, 24'd0);
    tab_wr(REG_IMAGE_HEIGHT, 24'd0);
    tab_wr(REG_SKIP_LOG2, 24'd7);
    tab_px(16'd5000, 8'h11, 8'h22, 8'h33);
    tab_pt(16'd0, 8'h44, 8'h55, 8'h66, 0, 0, 24'd0, 1'b0, 1'b1);
    tab_pt(16'd65535, 8'h77, 8'h88, 8'h99, 0, 0, 24'hFFFFFF, 1'b1, 1'b1);
    // far principal point with full-scale reciprocals saturates x and y negative
    tab_wr(REG_INV_FOCAL_X, 24'hFFFFFF);
    tab_wr(REG_INV_FOCAL_Y, 24'hFFFFFF);
    tab_wr(REG_CENTER_X, 24'd8191);
    tab_wr(REG_CENTER_Y, 24'd8191);
    tab_pt(16'd65535, 8'h01, 8'h02, 8'h04, COORD_MIN, COORD_MIN, 24'hFFFFFF, 1'b1, 1'b1);
    tab_px(16'd0, 8'h08, 8'h10, 8'h20);
    // oversized dimensions act as the maximum
    tab_wr(REG_IMAGE_WIDTH, 24'd4095);
    tab_wr(REG_IMAGE_HEIGHT, 24'd4095);
    tab_pt(16'd65535, 8'h40, 8'h80, 8'hFE, COORD_MIN, COORD_MIN, 24'hFFFFFF, 1'b1, 1'b0);
    tab_px(16'd300, 8'hEF, 8'hDF, 8'hBF);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) begin
      if (table_rows[i].is_write) begin
        if (i > 0 && !table_rows[i-1].is_write) drain_points();
        write_reg(table_rows[i].idx, table_rows[i].data);
      end else begin
        if (i > 0 && table_rows[i-1].is_write) cfg_if.valid <= 1'b0;
        send_pixel(table_rows[i].px, table_rows[i].typed, table_rows[i].want);
      end
    end

    // every pixel a point, positive x saturation, no idling and a long output hold-off
    drain_points();
    set_camera(24'hFFFFFF, 24'hFFFFFF, '0, '0, 24'hFFFFFF, '0, 12'd300, 12'd4);
    no_idle = 1'b1;
    hold_request = 1'b1;
    repeat (STALL_WORDS) send_pixel(rand_pixel(), 1'b0, '0);
    no_idle = 1'b0;

    for (int s = 0; s < RANDOM_SETS; s++) begin
      drain_points();
      set_camera(rand_scale(), rand_scale(), rand_center(), rand_center(), rand_scale(),
                 SKIP_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) :
                                                       $urandom_range(0, 2)),
                 rand_dim(48), rand_dim(16));
      repeat ($urandom_range(80, 120)) send_pixel(rand_pixel(), 1'b0, '0);
    end

    drain_points();
    $display("%0d pixels sent over %0d register writes, %0d points compared",
             pixels_sent, regs_written, points_checked);
    $display("directed corners, random camera settings and frames, one long output stall");
    if (mismatches == 0) begin
      $display("depth_pixel_backprojection_core regression: pass");
    end else begin
      $display("depth_pixel_backprojection_core regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dpb_pkg.sv
src/dpb_if.sv
src/dpb_front.sv
src/dpb_queue.sv
src/dpb_back.sv
src/depth_pixel_backprojection_core.sv
bench/depth_pixel_backprojection_core_tb.sv
